// ===== sv/ksc_pkg.sv =====
// ksc_pkg: shared types and constants of the keyword streak confirmer.
// Used by ksc_ctrl, ksc_datapath and keyword_streak_confirmer; no dependencies.
`timescale 1ns / 1ps

package ksc_pkg;

    // Field widths
    localparam int PROB_BITS   = 16;
    localparam int COUNT_BITS  = 4;
    localparam int CLASS_BITS  = 3;
    localparam int THR_BITS    = 7;
    localparam int NUM_CLASSES = 5;

    // Configuration registers
    localparam int NEED_REG_W = NUM_CLASSES * COUNT_BITS;
    localparam int THR_REG_W  = NUM_CLASSES * THR_BITS;
    localparam int CFG_DATA_W = (NEED_REG_W > THR_REG_W) ? NEED_REG_W : THR_REG_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NEED_COUNTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS  = CFG_IDX_W'(1);

    // Needed counts after reset: 2,2,4,4,2 for classes 0..4
    localparam logic [NEED_REG_W-1:0] NEED_RESET =
        (NEED_REG_W'(2) << (COUNT_BITS * 0)) | (NEED_REG_W'(2) << (COUNT_BITS * 1)) |
        (NEED_REG_W'(4) << (COUNT_BITS * 2)) | (NEED_REG_W'(4) << (COUNT_BITS * 3)) |
        (NEED_REG_W'(2) << (COUNT_BITS * 4));

    // Probability sum and divider
    localparam int SUM_W     = PROB_BITS + COUNT_BITS;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int PROD_W    = PROB_BITS + THR_BITS;
    localparam int PCT_FULL  = 100;

    // Class codes
    localparam logic [CLASS_BITS-1:0] CLS_OFF     = CLASS_BITS'(0);
    localparam logic [CLASS_BITS-1:0] CLS_ON      = CLASS_BITS'(1);
    localparam logic [CLASS_BITS-1:0] CLS_OTHER   = CLASS_BITS'(2);
    localparam logic [CLASS_BITS-1:0] CLS_SILENCE = CLASS_BITS'(3);
    localparam logic [CLASS_BITS-1:0] CLS_SWITCH  = CLASS_BITS'(4);

    // Function codes
    localparam logic FUNC_PROCESS = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [CLASS_BITS-1:0] word_class;
        logic [PROB_BITS-1:0]  probability;
    } t_in_item;

    typedef struct packed {
        logic                  confirmed;
        logic [CLASS_BITS-1:0] confirmed_class;
        logic [PROB_BITS-1:0]  mean_probability;
        logic [COUNT_BITS-1:0] streak_length;
        logic                  bad_class;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take the input item, update detection state
        logic div_step;  // one restoring-division step
        logic push;      // move the finished result to the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;  // item being loaded confirms a word
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

// ===== sv/ksc_ctrl.sv =====
// ksc_ctrl: sequencer of the keyword streak confirmer.
// Depends on ksc_pkg; drives ksc_datapath through t_dp_cmd.
`timescale 1ns / 1ps

module ksc_ctrl
    import ksc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_step, n_step;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.need_div) begin
                        n_state = S_DIV;
                        n_step  = DIV_CNT_W'(SUM_W - 1);
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== sv/ksc_datapath.sv =====
// ksc_datapath: configuration, detection state, serial divider and output register.
// Depends on ksc_pkg; sequenced by ksc_ctrl.
`timescale 1ns / 1ps

module ksc_datapath
    import ksc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item             o_out_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready
);

    function automatic logic [COUNT_BITS-1:0] f_need(input logic [NEED_REG_W-1:0] reg_v,
                                                     input logic [CLASS_BITS-1:0] cls);
        logic [COUNT_BITS-1:0] v;
        v = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (cls == CLASS_BITS'(k)) v = reg_v[k*COUNT_BITS +: COUNT_BITS];
        end
        return v;
    endfunction

    function automatic logic [THR_BITS-1:0] f_thr(input logic [THR_REG_W-1:0] reg_v,
                                                  input logic [CLASS_BITS-1:0] cls);
        logic [THR_BITS-1:0] v;
        v = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (cls == CLASS_BITS'(k)) v = reg_v[k*THR_BITS +: THR_BITS];
        end
        return v;
    endfunction

    // Configuration
    logic [NEED_REG_W-1:0] r_need_reg;
    logic [THR_REG_W-1:0]  r_thr_reg;

    // Detection state
    logic                  r_streak_active, n_streak_active;
    logic [CLASS_BITS-1:0] r_streak_class,  n_streak_class;
    logic [COUNT_BITS-1:0] r_streak_count,  n_streak_count;
    logic [SUM_W-1:0]      r_prob_sum,      n_prob_sum;
    logic [COUNT_BITS-1:0] r_gap_count,     n_gap_count;
    logic [CLASS_BITS-1:0] r_gap_class,     n_gap_class;
    logic                  r_lock_active,   n_lock_active;
    logic [CLASS_BITS-1:0] r_locked_class,  n_locked_class;

    // Pending result and divider
    t_out_item             r_res, n_res;
    logic [SUM_W-1:0]      r_div_num;
    logic [COUNT_BITS-1:0] r_div_den;
    logic [COUNT_BITS-1:0] r_div_rem;
    t_out_item             r_out_item, n_out_item;
    logic                  r_out_valid;

    logic [CLASS_BITS-1:0] cls;
    logic [PROB_BITS-1:0]  prob;
    logic [COUNT_BITS-1:0] need;
    logic [THR_BITS-1:0]   thr;
    logic [PROD_W-1:0]     prob_pct;
    logic [PROD_W-1:0]     thr_scaled;
    logic                  is_cmd, passes, is_bad, lock_hit;
    logic                  gap_restart, gap_end, fresh, confirm;
    logic [COUNT_BITS-1:0] gap_new, cnt_new;
    logic [SUM_W-1:0]      sum_new;
    logic [COUNT_BITS:0]   rem_shift;
    logic                  rem_ge;

    assign cls        = i_in_item.word_class;
    assign prob       = i_in_item.probability;
    assign need       = f_need(r_need_reg, cls);
    assign thr        = f_thr(r_thr_reg, cls);
    assign prob_pct   = PROD_W'(prob) * PROD_W'(PCT_FULL);
    assign thr_scaled = {thr, {PROB_BITS{1'b0}}};
    assign is_bad     = (cls > CLS_SWITCH);
    assign lock_hit   = r_lock_active && (cls == r_locked_class);
    assign is_cmd     = (cls == CLS_OFF) || (cls == CLS_ON) || (cls == CLS_SWITCH);
    assign passes     = is_cmd && ((thr == '0) || (prob_pct >= thr_scaled));

    // Gap path
    assign gap_restart = (r_gap_count == '0) || (r_gap_class != cls);
    assign gap_new     = (gap_restart ? '0 : r_gap_count) + 1'b1;
    assign gap_end     = (gap_new >= need);

    // Streak path
    assign fresh   = !r_streak_active || (cls != r_streak_class);
    assign cnt_new = (fresh ? '0 : r_streak_count) + 1'b1;
    assign sum_new = (fresh ? '0 : r_prob_sum) + SUM_W'(prob);
    assign confirm = (cnt_new >= need);

    assign o_status.need_div = (i_in_item.func == FUNC_PROCESS) && !is_bad && !lock_hit &&
                               passes && confirm;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_streak_active = r_streak_active;
        n_streak_class  = r_streak_class;
        n_streak_count  = r_streak_count;
        n_prob_sum      = r_prob_sum;
        n_gap_count     = r_gap_count;
        n_gap_class     = r_gap_class;
        n_lock_active   = r_lock_active;
        n_locked_class  = r_locked_class;
        n_res           = '0;
        if (i_in_item.func == FUNC_CLEAR) begin
            n_streak_active = 1'b0;
            n_streak_class  = '0;
            n_streak_count  = '0;
            n_prob_sum      = '0;
            n_gap_count     = '0;
            n_gap_class     = '0;
            n_lock_active   = 1'b0;
            n_locked_class  = '0;
        end else if (is_bad) begin
            n_res.bad_class     = 1'b1;
            n_res.streak_length = r_streak_count;
        end else if (lock_hit) begin
            n_res.streak_length = r_streak_count;
        end else if (!passes) begin
            n_lock_active = 1'b0;
            if (is_cmd || gap_end) begin
                n_streak_active = 1'b0;
                n_streak_count  = '0;
                n_prob_sum      = '0;
            end
            n_gap_count         = gap_end ? '0 : gap_new;
            n_gap_class         = gap_end ? '0 : cls;
            n_res.streak_length = (is_cmd || gap_end) ? '0 : r_streak_count;
        end else begin
            n_lock_active       = 1'b0;
            n_streak_class      = cls;
            n_gap_count         = '0;
            n_gap_class         = fresh ? '0 : r_gap_class;
            n_res.streak_length = cnt_new;
            if (confirm) begin
                n_streak_active       = 1'b0;
                n_streak_count        = '0;
                n_prob_sum            = '0;
                n_gap_class           = '0;
                n_lock_active         = 1'b1;
                n_locked_class        = cls;
                n_res.confirmed       = 1'b1;
                n_res.confirmed_class = cls;
            end else begin
                n_streak_active = 1'b1;
                n_streak_count  = cnt_new;
                n_prob_sum      = sum_new;
            end
        end
    end

    // Restoring division, one quotient bit per step, quotient shifts into r_div_num
    assign rem_shift = {r_div_rem, r_div_num[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_div_den});

    // Finished result with the quotient filled in on a confirmation
    always_comb begin
        n_out_item                  = r_res;
        n_out_item.mean_probability = r_res.confirmed ? r_div_num[PROB_BITS-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_reg      <= NEED_RESET;
            r_thr_reg       <= '0;
            r_streak_active <= 1'b0;
            r_streak_class  <= '0;
            r_streak_count  <= '0;
            r_prob_sum      <= '0;
            r_gap_count     <= '0;
            r_gap_class     <= '0;
            r_lock_active   <= 1'b0;
            r_locked_class  <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_NEED_COUNTS) r_need_reg <= i_cfg_data[NEED_REG_W-1:0];
                if (i_cfg_index == REG_THRESHOLDS)  r_thr_reg  <= i_cfg_data[THR_REG_W-1:0];
            end
            if (i_cmd.load) begin
                r_streak_active <= n_streak_active;
                r_streak_class  <= n_streak_class;
                r_streak_count  <= n_streak_count;
                r_prob_sum      <= n_prob_sum;
                r_gap_count     <= n_gap_count;
                r_gap_class     <= n_gap_class;
                r_lock_active   <= n_lock_active;
                r_locked_class  <= n_locked_class;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res     <= n_res;
            r_div_num <= sum_new;
            r_div_den <= cnt_new;
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= rem_ge ? COUNT_BITS'(rem_shift - {1'b0, r_div_den})
                                : rem_shift[COUNT_BITS-1:0];
            r_div_num <= {r_div_num[SUM_W-2:0], rem_ge};
        end
        if (i_cmd.push) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_item  = r_out_item;
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/keyword_streak_confirmer.sv =====
// keyword_streak_confirmer: top level, joins the sequencer and the datapath.
// Depends on ksc_pkg, ksc_ctrl and ksc_datapath.
//
// Takes one keyword-classifier frame per item (class and Q0.16 probability) and
// returns one result item per frame. A command class (off, on, switch) is
// confirmed after its configured number of consecutive frames at or above its
// percent threshold; the result then carries the class and the floor of the
// streak's mean probability. Timing: a frame that does not confirm goes from the
// push state into the output register and the next frame is taken the cycle
// after; a confirming frame first passes through the one-bit-per-cycle restoring
// divider that forms sum/count over the 20-bit probability sum. A result waits
// in the push state while the output register still holds an unaccepted result.
// One item is in work at a time; the output register holds a finished result
// while the next item is accepted. Configuration writes are taken every cycle,
// but must only arrive while the block is idle. func = 1 clears all detection
// state.
`timescale 1ns / 1ps

module keyword_streak_confirmer
    import ksc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // frame channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    // register write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // registers always writable
    assign o_cfg_ready = 1'b1;

    // sequencer: idle -> (divide) -> push to output register
    ksc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // state update, divider and output register
    ksc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

// ===== verif/tb_keyword_streak_confirmer.sv =====
// tb_keyword_streak_confirmer: self-checking testbench of keyword_streak_confirmer.
// Scores every result item against an in-bench model of the streak/gap/lock rules.
// Depends on ksc_pkg and keyword_streak_confirmer.
`timescale 1ns / 1ps

module tb_keyword_streak_confirmer;
    import ksc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SEGMENTS    = 8;
    localparam int SEG_FRAMES  = 128;
    // margin after the queues drain, for anything still in flight
    localparam int SETTLE      = 30;

    // DUT ports, inputs all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    keyword_streak_confirmer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Frames waiting to be sent, and the result each accepted frame should give
    t_in_item    frame_q[$];
    t_out_item   verdict_q[$];
    int unsigned frames_sent  = 0;
    int unsigned frames_taken = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;

    // Idle profile of the current phase, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Mirror of the registers as the block should hold them
    logic [NEED_REG_W-1:0] need_mirror = NEED_RESET;
    logic [THR_REG_W-1:0]  thr_mirror  = '0;

    // Mirror of the detection state
    logic                  streak_on    = 1'b0;
    logic [CLASS_BITS-1:0] streak_cls   = '0;
    logic [COUNT_BITS-1:0] streak_cnt   = '0;
    logic [SUM_W-1:0]      streak_sum   = '0;
    logic [COUNT_BITS-1:0] gap_cnt      = '0;
    logic [CLASS_BITS-1:0] gap_cls      = '0;
    logic                  lock_on      = 1'b0;
    logic [CLASS_BITS-1:0] lock_cls     = '0;

    function automatic void end_streak();
        streak_on  = 1'b0;
        streak_cnt = '0;
        streak_sum = '0;
    endfunction

    // Works out the result of one accepted frame and advances the state mirror
    function automatic t_out_item judge_frame(t_in_item f);
        t_out_item             r;
        logic [COUNT_BITS-1:0] need;
        logic [THR_BITS-1:0]   thr;
        logic                  is_cmd;
        logic                  passes;
        r = '0;
        if (f.func == FUNC_CLEAR) begin
            end_streak();
            streak_cls = '0;
            gap_cnt    = '0;
            gap_cls    = '0;
            lock_on    = 1'b0;
            lock_cls   = '0;
            return r;
        end
        // classes above switch are flagged and otherwise ignored
        if (f.word_class >= NUM_CLASSES) begin
            r.streak_length = streak_cnt;
            r.bad_class     = 1'b1;
            return r;
        end
        // after a confirmation the same class is ignored until another arrives
        if (lock_on) begin
            if (f.word_class == lock_cls) begin
                r.streak_length = streak_cnt;
                return r;
            end
            lock_on = 1'b0;
        end

        need   = need_mirror[COUNT_BITS*f.word_class +: COUNT_BITS];
        thr    = thr_mirror[THR_BITS*f.word_class +: THR_BITS];
        is_cmd = (f.word_class == CLS_OFF) || (f.word_class == CLS_ON) ||
                 (f.word_class == CLS_SWITCH);
        passes = is_cmd && ((thr == '0) ||
                 (32'(f.probability) * PCT_FULL >= (32'(thr) << PROB_BITS)));

        if (!passes) begin
            if (is_cmd)
                end_streak();
            if ((gap_cnt == '0) || (gap_cls != f.word_class)) begin
                gap_cls = f.word_class;
                gap_cnt = '0;
            end
            gap_cnt++;
            // a needed count of zero acts as one: every gap frame ends the streak
            if (gap_cnt >= need) begin
                end_streak();
                gap_cnt = '0;
                gap_cls = '0;
            end
            r.streak_length = streak_cnt;
            return r;
        end

        gap_cnt = '0;
        if (!streak_on || (f.word_class != streak_cls)) begin
            streak_on  = 1'b1;
            streak_cls = f.word_class;
            streak_cnt = '0;
            gap_cls    = '0;
            streak_sum = '0;
        end
        streak_cnt++;
        streak_sum += SUM_W'(f.probability);
        r.streak_length = streak_cnt;
        if (streak_cnt >= need) begin
            r.confirmed        = 1'b1;
            r.confirmed_class  = f.word_class;
            r.mean_probability = PROB_BITS'(streak_sum / streak_cnt);
            end_streak();
            gap_cnt  = '0;
            gap_cls  = '0;
            lock_on  = 1'b1;
            lock_cls = f.word_class;
        end
        return r;
    endfunction

    // Driver: inputs change on the falling edge; a frame stays up until taken
    always @(negedge i_clk) begin
        if (frames_sent == frames_taken) begin
            if (i_rst_n && (frame_q.size() > 0) && ($urandom_range(99) >= send_idle_pct)) begin
                i_in_item  <= frame_q.pop_front();
                i_in_valid <= 1'b1;
                frames_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: everything sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NEED_COUNTS: need_mirror = i_cfg_data[NEED_REG_W-1:0];
                    REG_THRESHOLDS:  thr_mirror  = i_cfg_data[THR_REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                verdict_q.push_back(judge_frame(i_in_item));
                frames_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: c=%0d cls=%0d mean=%h len=%0d bad=%0d",
                                 o_out_item.confirmed, o_out_item.confirmed_class,
                                 o_out_item.mean_probability, o_out_item.streak_length,
                                 o_out_item.bad_class);
                end else begin
                    t_out_item want;
                    want = verdict_q.pop_front();
                    if ((o_out_item.confirmed        !== want.confirmed)        ||
                        (o_out_item.confirmed_class  !== want.confirmed_class)  ||
                        (o_out_item.mean_probability !== want.mean_probability) ||
                        (o_out_item.streak_length    !== want.streak_length)    ||
                        (o_out_item.bad_class        !== want.bad_class)) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: want c=%0d cls=%0d mean=%h len=%0d bad=%0d",
                                   want.confirmed, want.confirmed_class,
                                   want.mean_probability, want.streak_length,
                                   want.bad_class);
                            $display(" / got c=%0d cls=%0d mean=%h len=%0d bad=%0d",
                                     o_out_item.confirmed, o_out_item.confirmed_class,
                                     o_out_item.mean_probability, o_out_item.streak_length,
                                     o_out_item.bad_class);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_keyword_streak_confirmer: FAIL");
            $finish;
        end
    end

    task automatic push_frame(logic func, logic [CLASS_BITS-1:0] cls,
                              logic [PROB_BITS-1:0] prob);
        t_in_item f;
        f.func        = func;
        f.word_class  = cls;
        f.probability = prob;
        frame_q.push_back(f);
    endtask

    // Sender holds off until every frame is taken and every result has come
    task automatic wait_idle();
        while ((frame_q.size() != 0) || (frames_sent != frames_taken) ||
               (verdict_q.size() != 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly short counts, now and then zero or the maximum
    function automatic logic [NEED_REG_W-1:0] random_needs();
        logic [NEED_REG_W-1:0] w;
        int unsigned           r;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            r = $urandom_range(99);
            if (r < 8)
                w[COUNT_BITS*c +: COUNT_BITS] = '0;
            else if (r < 16)
                w[COUNT_BITS*c +: COUNT_BITS] = '1;
            else
                w[COUNT_BITS*c +: COUNT_BITS] = COUNT_BITS'($urandom_range(1, 5));
        end
        return w;
    endfunction

    // Mostly real percentages, some disabled, some above 100 (never met)
    function automatic logic [THR_REG_W-1:0] random_thresholds();
        logic [THR_REG_W-1:0] w;
        int unsigned          r;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            r = $urandom_range(99);
            if (r < 15)
                w[THR_BITS*c +: THR_BITS] = '0;
            else if (r < 25)
                w[THR_BITS*c +: THR_BITS] = THR_BITS'($urandom_range(101, 127));
            else
                w[THR_BITS*c +: THR_BITS] = THR_BITS'($urandom_range(1, 100));
        end
        return w;
    endfunction

    // Runs of one class sized around its needed count, probabilities mostly high
    // or near the threshold, with clears and out-of-range classes as noise
    task automatic queue_frames(int n, logic [NEED_REG_W-1:0] nw, logic [THR_REG_W-1:0] tw);
        int unsigned           sel;
        int unsigned           run;
        int unsigned           k;
        int unsigned           bound_p;
        logic [CLASS_BITS-1:0] cls;
        logic [PROB_BITS-1:0]  p;
        while (n > 0) begin
            sel = $urandom_range(99);
            if (sel < 3) begin
                push_frame(FUNC_CLEAR, CLASS_BITS'($urandom), PROB_BITS'($urandom));
                n--;
            end else if (sel < 7) begin
                push_frame(FUNC_PROCESS, CLASS_BITS'($urandom_range(5, 7)), PROB_BITS'($urandom));
                n--;
            end else begin
                if (sel < 57) begin
                    k   = $urandom_range(2);
                    cls = (k == 0) ? CLS_OFF : (k == 1) ? CLS_ON : CLS_SWITCH;
                end else begin
                    cls = $urandom_range(1) ? CLS_SILENCE : CLS_OTHER;
                end
                run     = $urandom_range(1, nw[COUNT_BITS*cls +: COUNT_BITS] + 2);
                // smallest probability that meets this class's threshold
                bound_p = (tw[THR_BITS*cls +: THR_BITS] * (1 << PROB_BITS) + 99) / 100;
                repeat (run) begin
                    if (n > 0) begin
                        sel = $urandom_range(99);
                        if (sel < 30) begin
                            p = PROB_BITS'($urandom);
                        end else if (sel < 55) begin
                            k = bound_p + $urandom_range(2);
                            if (k > 0)
                                k--;
                            if (k > (1 << PROB_BITS) - 1)
                                k = (1 << PROB_BITS) - 1;
                            p = PROB_BITS'(k);
                        end else begin
                            p = {2'b11, (PROB_BITS-2)'($urandom)};
                        end
                        push_frame(FUNC_PROCESS, cls, p);
                        n--;
                    end
                end
            end
        end
    endtask

    // Stimulus
    initial begin
        int unsigned           send_pct[4];
        int unsigned           stall_pct[4];
        logic [NEED_REG_W-1:0] nw;
        logic [THR_REG_W-1:0]  tw;

        send_pct  = '{0, 65, 0, 13};
        stall_pct = '{0, 0, 65, 13};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, default counts 2,2,4,4,2 and thresholds off
        write_reg(REG_NEED_COUNTS, CFG_DATA_W'(NEED_RESET));
        write_reg(REG_THRESHOLDS, '0);
        push_frame(FUNC_CLEAR,   3'd7,       16'hFFFF);   // clear gives all zeros
        push_frame(FUNC_PROCESS, CLS_OFF,    16'h0000);
        push_frame(FUNC_PROCESS, CLS_OFF,    16'hFFFF);   // confirms, mean 7FFF
        push_frame(FUNC_PROCESS, CLS_OFF,    16'h1234);   // locked, ignored
        push_frame(FUNC_PROCESS, 3'd5,       16'h0000);   // out-of-range classes
        push_frame(FUNC_PROCESS, 3'd6,       16'h5555);
        push_frame(FUNC_PROCESS, 3'd7,       16'hFFFF);
        push_frame(FUNC_PROCESS, CLS_ON,     16'hFFFF);
        push_frame(FUNC_PROCESS, CLS_OTHER,  16'h0000);   // short gap keeps the streak
        push_frame(FUNC_PROCESS, CLS_ON,     16'hFFFF);
        repeat (4) push_frame(FUNC_PROCESS, CLS_SILENCE, 16'h0000);  // gap reaches its needed count
        push_frame(FUNC_PROCESS, CLS_SWITCH, 16'h8000);
        push_frame(FUNC_PROCESS, CLS_SWITCH, 16'h8001);
        push_frame(FUNC_PROCESS, CLS_ON,     16'h1111);
        push_frame(FUNC_CLEAR,   CLS_ON,     16'h0000);   // clear mid-streak
        push_frame(FUNC_PROCESS, CLS_ON,     16'h2222);
        wait_idle();

        // Directed: zero and full counts, exact threshold edges, threshold above 100
        write_reg(REG_NEED_COUNTS, CFG_DATA_W'(20'h3_0_1_F_0));
        write_reg(REG_THRESHOLDS,
                  CFG_DATA_W'((35'd127 << 28) | (35'd100 << 14) | (35'd1 << 7) | 35'd50));
        push_frame(FUNC_PROCESS, CLS_OFF,     16'h8000);  // exactly 50 %, zero count
        push_frame(FUNC_PROCESS, CLS_OTHER,   16'hFFFF);  // drops lock, ends at once
        push_frame(FUNC_PROCESS, CLS_OFF,     16'h7FFF);  // just under 50 %
        push_frame(FUNC_PROCESS, CLS_SWITCH,  16'hFFFF);  // threshold 127 never met
        push_frame(FUNC_PROCESS, CLS_ON,      16'h028F);  // just under 1 %
        push_frame(FUNC_PROCESS, CLS_ON,      16'h0290);  // first value at or above 1 %
        push_frame(FUNC_PROCESS, CLS_SILENCE, 16'h0000);
        wait_idle();

        // Random segments: two per idle profile, each with its own register setting
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin nw = NEED_RESET;     tw = '0;                  end
                1: begin nw = '1;             tw = '0;                  end
                2: begin nw = '0;             tw = '0;                  end
                3: begin nw = random_needs(); tw = '1;                  end
                6: begin nw = '1;             tw = random_thresholds(); end
                default: begin nw = random_needs(); tw = random_thresholds(); end
            endcase
            send_idle_pct  = send_pct[seg/2];
            recv_stall_pct = stall_pct[seg/2];
            write_reg(REG_NEED_COUNTS, CFG_DATA_W'(nw));
            write_reg(REG_THRESHOLDS, CFG_DATA_W'(tw));
            queue_frames(SEG_FRAMES, nw, tw);
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb_keyword_streak_confirmer: PASS");
        else
            $display("tb_keyword_streak_confirmer: FAIL");
        $finish;
    end

endmodule
